// ===== rtl/psfp_pkg.sv =====
package psfp_pkg;

    localparam int SPEED_WIDTH    = 48;
    localparam int POS_WIDTH_DEF  = 32;
    localparam int TIME_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_TIME_BACK = 2'd1;
    localparam logic [1:0] STATUS_SINGLE    = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_EMIT_FIRST,
        ST_EMIT_LAST
    } ctl_state_t;

    typedef enum logic [2:0] {
        EN_IDLE,
        EN_SQUARE,
        EN_PREP,
        EN_ROOT,
        EN_DIVIDE
    } eng_state_t;

endpackage

// ===== rtl/psfp_engine.sv =====
module psfp_engine #(
    parameter int POS_WIDTH  = psfp_pkg::POS_WIDTH_DEF,
    parameter int TIME_WIDTH = psfp_pkg::TIME_WIDTH_DEF,
    parameter int FRAC_BITS  = psfp_pkg::FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [POS_WIDTH-1:0]             dx_mag,
    input  logic [POS_WIDTH-1:0]             dy_mag,
    input  logic [TIME_WIDTH-1:0]            dt,
    output logic                             done,
    output logic [psfp_pkg::SPEED_WIDTH-1:0] speed
);
    import psfp_pkg::*;

    localparam int RW    = POS_WIDTH + FRAC_BITS + 1;
    localparam int NUM_W = 2 * RW;
    localparam int SUM_W = 2 * POS_WIDTH + 1;
    localparam int PRD_W = 2 * POS_WIDTH;
    localparam int CNT_W = $clog2(RW);
    localparam int EXT_W = (RW > SPEED_WIDTH) ? RW : SPEED_WIDTH;

    eng_state_t             state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   done_reg, done_next;

    logic [POS_WIDTH-1:0]   dx_reg, dx_next;
    logic [POS_WIDTH-1:0]   dy_reg, dy_next;
    logic [TIME_WIDTH-1:0]  dt_reg, dt_next;
    logic [PRD_W-1:0]       prodx_reg, prodx_next;
    logic [PRD_W-1:0]       prody_reg, prody_next;
    logic [NUM_W-1:0]       num_reg, num_next;
    logic [RW+1:0]          rem_reg, rem_next;
    logic [RW-1:0]          root_reg, root_next;
    logic [TIME_WIDTH-1:0]  div_rem_reg, div_rem_next;

    logic [POS_WIDTH:0]     addx, addy;
    logic [SUM_W-1:0]       sum;
    logic [RW+1:0]          rem_sh, trial, rem_diff;
    logic                   root_fit;
    logic [TIME_WIDTH:0]    div_sh, div_diff;
    logic                   div_fit;
    logic [EXT_W-1:0]       q_ext;
    logic                   sat;

    // shift-add squaring, lsb first, product shifts right
    assign addx = {1'b0, prodx_reg[PRD_W-1:POS_WIDTH]}
                + (prodx_reg[0] ? {1'b0, dx_reg} : '0);
    assign addy = {1'b0, prody_reg[PRD_W-1:POS_WIDTH]}
                + (prody_reg[0] ? {1'b0, dy_reg} : '0);
    assign sum  = SUM_W'(prodx_reg) + SUM_W'(prody_reg);

    // restoring square root, two radicand bits per step
    assign rem_sh   = {rem_reg[RW-1:0], num_reg[NUM_W-1 -: 2]};
    assign trial    = {root_reg, 2'b01};
    assign root_fit = (rem_sh >= trial);
    assign rem_diff = rem_sh - trial;

    // restoring division, quotient shifts into the root register
    assign div_sh   = {div_rem_reg, root_reg[RW-1]};
    assign div_fit  = (div_sh >= {1'b0, dt_reg});
    assign div_diff = div_sh - {1'b0, dt_reg};

    assign q_ext = EXT_W'(root_reg);
    assign sat   = |(q_ext >> SPEED_WIDTH);
    assign speed = sat ? '1 : q_ext[SPEED_WIDTH-1:0];
    assign done  = done_reg;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        done_next    = 1'b0;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        dt_next      = dt_reg;
        prodx_next   = prodx_reg;
        prody_next   = prody_reg;
        num_next     = num_reg;
        rem_next     = rem_reg;
        root_next    = root_reg;
        div_rem_next = div_rem_reg;
        unique case (state_reg)
            EN_IDLE:
            begin
                if (start)
                begin
                    dx_next    = dx_mag;
                    dy_next    = dy_mag;
                    dt_next    = dt;
                    prodx_next = PRD_W'(dx_mag);
                    prody_next = PRD_W'(dy_mag);
                    cnt_next   = CNT_W'(POS_WIDTH - 1);
                    state_next = EN_SQUARE;
                end
            end
            EN_SQUARE:
            begin
                prodx_next = {addx, prodx_reg[POS_WIDTH-1:1]};
                prody_next = {addy, prody_reg[POS_WIDTH-1:1]};
                if (cnt_reg == '0)
                    state_next = EN_PREP;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            EN_PREP:
            begin
                num_next   = NUM_W'(sum) << (2 * FRAC_BITS);
                rem_next   = '0;
                root_next  = '0;
                cnt_next   = CNT_W'(RW - 1);
                state_next = EN_ROOT;
            end
            EN_ROOT:
            begin
                num_next = num_reg << 2;
                if (root_fit)
                begin
                    rem_next  = rem_diff;
                    root_next = {root_reg[RW-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[RW-2:0], 1'b0};
                end
                if (cnt_reg == '0)
                begin
                    cnt_next     = CNT_W'(RW - 1);
                    div_rem_next = '0;
                    state_next   = EN_DIVIDE;
                end
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            EN_DIVIDE:
            begin
                div_rem_next = div_fit ? div_diff[TIME_WIDTH-1:0] : div_sh[TIME_WIDTH-1:0];
                root_next    = {root_reg[RW-2:0], div_fit};
                if (cnt_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = EN_IDLE;
                end
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            default:
            begin
                state_next = EN_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= EN_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        dt_reg      <= dt_next;
        prodx_reg   <= prodx_next;
        prody_reg   <= prody_next;
        num_reg     <= num_next;
        rem_reg     <= rem_next;
        root_reg    <= root_next;
        div_rem_reg <= div_rem_next;
    end

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("engine done held longer than one cycle");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (state_reg == EN_IDLE))
        else $error("engine started while busy");

    a_root_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == EN_ROOT) |-> !rem_reg[RW+1])
        else $error("square root remainder overflow");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == EN_DIVIDE) |-> (div_rem_reg < dt_reg))
        else $error("division remainder not below divisor");

endmodule

// ===== rtl/planar_speed_from_positions_unit.sv =====
// Finite-difference speed of a 2-D track. Each sample after the first of a run gives one
// result for the previous sample's time, speed = floor(2^FRAC_BITS * sqrt(dx^2 + dy^2) / dt),
// saturated at all ones of the 48-bit Q32.16 output; the sample marked end_of_run also gives
// a second result for its own time with run_done set. A time that does not increase gives
// speed 0 and status 1, a run of one sample gives speed 0 and status 2. One sample is handled
// at a time: a moving sample's speed is worked out in the engine by the bit-serial squaring,
// the one-bit-per-cycle square root and the one-bit-per-cycle divider; the next sample is
// taken only once its result has gone to the output register, and once the second result
// has too when the sample ended a run. The first sample of a run only loads the prior
// registers and leaves the unit ready; the other cases pass through the emit states. A
// finished result sits in the output register while the next sample is accepted and computed.
module planar_speed_from_positions_unit #(
    parameter int POS_WIDTH  = psfp_pkg::POS_WIDTH_DEF,
    parameter int TIME_WIDTH = psfp_pkg::TIME_WIDTH_DEF,
    parameter int FRAC_BITS  = psfp_pkg::FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [TIME_WIDTH-1:0]            sample_time,
    input  logic signed [POS_WIDTH-1:0]      pos_x,
    input  logic signed [POS_WIDTH-1:0]      pos_y,
    input  logic                             end_of_run,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [TIME_WIDTH-1:0]            speed_time,
    output logic [psfp_pkg::SPEED_WIDTH-1:0] speed_value,
    output logic [1:0]                       step_status,
    output logic                             run_done
);
    import psfp_pkg::*;

    ctl_state_t             state_reg, state_next;
    logic [TIME_WIDTH-1:0]  prior_time_reg, prior_time_next;
    logic [POS_WIDTH-1:0]   prior_x_reg, prior_x_next;
    logic [POS_WIDTH-1:0]   prior_y_reg, prior_y_next;
    logic                   have_prior_reg, have_prior_next;
    logic                   out_valid_reg, out_valid_next;

    logic [TIME_WIDTH-1:0]  time1_reg, time1_next;
    logic [TIME_WIDTH-1:0]  time2_reg, time2_next;
    logic [SPEED_WIDTH-1:0] res_speed_reg, res_speed_next;
    logic [1:0]             res_status_reg, res_status_next;
    logic                   last_reg, last_next;
    logic [TIME_WIDTH-1:0]  speed_time_reg, speed_time_next;
    logic [SPEED_WIDTH-1:0] speed_value_reg, speed_value_next;
    logic [1:0]             step_status_reg, step_status_next;
    logic                   run_done_reg, run_done_next;

    logic                   accept, time_fwd, out_free, eng_start, eng_done;
    logic [POS_WIDTH:0]     dx_diff, dx_neg, dy_diff, dy_neg;
    logic [POS_WIDTH-1:0]   dx_mag, dy_mag;
    logic [TIME_WIDTH-1:0]  dt;
    logic [SPEED_WIDTH-1:0] eng_speed;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign time_fwd = (sample_time > prior_time_reg);
    assign out_free = !out_valid_reg || out_ready;

    // sign-extended differences, magnitude fits POS_WIDTH bits
    assign dx_diff = {pos_x[POS_WIDTH-1], pos_x} - {prior_x_reg[POS_WIDTH-1], prior_x_reg};
    assign dy_diff = {pos_y[POS_WIDTH-1], pos_y} - {prior_y_reg[POS_WIDTH-1], prior_y_reg};
    assign dx_neg  = -dx_diff;
    assign dy_neg  = -dy_diff;
    assign dx_mag  = dx_diff[POS_WIDTH] ? dx_neg[POS_WIDTH-1:0] : dx_diff[POS_WIDTH-1:0];
    assign dy_mag  = dy_diff[POS_WIDTH] ? dy_neg[POS_WIDTH-1:0] : dy_diff[POS_WIDTH-1:0];
    assign dt      = sample_time - prior_time_reg;

    assign eng_start = accept && have_prior_reg && time_fwd;

    psfp_engine #(
        .POS_WIDTH  (POS_WIDTH),
        .TIME_WIDTH (TIME_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (eng_start),
        .dx_mag (dx_mag),
        .dy_mag (dy_mag),
        .dt     (dt),
        .done   (eng_done),
        .speed  (eng_speed)
    );

    always_comb
    begin
        state_next       = state_reg;
        prior_time_next  = prior_time_reg;
        prior_x_next     = prior_x_reg;
        prior_y_next     = prior_y_reg;
        have_prior_next  = have_prior_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        time1_next       = time1_reg;
        time2_next       = time2_reg;
        res_speed_next   = res_speed_reg;
        res_status_next  = res_status_reg;
        last_next        = last_reg;
        speed_time_next  = speed_time_reg;
        speed_value_next = speed_value_reg;
        step_status_next = step_status_reg;
        run_done_next    = run_done_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    time2_next = sample_time;
                    last_next  = end_of_run;
                    if (!have_prior_reg)
                    begin
                        if (end_of_run)
                        begin
                            res_speed_next  = '0;
                            res_status_next = STATUS_SINGLE;
                            state_next      = ST_EMIT_LAST;
                        end
                        else
                        begin
                            prior_time_next = sample_time;
                            prior_x_next    = pos_x;
                            prior_y_next    = pos_y;
                            have_prior_next = 1'b1;
                        end
                    end
                    else
                    begin
                        time1_next = prior_time_reg;
                        if (time_fwd)
                        begin
                            res_status_next = STATUS_OK;
                            state_next      = ST_CALC;
                        end
                        else
                        begin
                            res_speed_next  = '0;
                            res_status_next = STATUS_TIME_BACK;
                            state_next      = ST_EMIT_FIRST;
                        end
                        if (end_of_run)
                        begin
                            prior_time_next = '0;
                            prior_x_next    = '0;
                            prior_y_next    = '0;
                            have_prior_next = 1'b0;
                        end
                        else
                        begin
                            prior_time_next = sample_time;
                            prior_x_next    = pos_x;
                            prior_y_next    = pos_y;
                        end
                    end
                end
            end
            ST_CALC:
            begin
                if (eng_done)
                begin
                    res_speed_next = eng_speed;
                    state_next     = ST_EMIT_FIRST;
                end
            end
            ST_EMIT_FIRST:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    speed_time_next  = time1_reg;
                    speed_value_next = res_speed_reg;
                    step_status_next = res_status_reg;
                    run_done_next    = 1'b0;
                    state_next       = last_reg ? ST_EMIT_LAST : ST_IDLE;
                end
            end
            ST_EMIT_LAST:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    speed_time_next  = time2_reg;
                    speed_value_next = res_speed_reg;
                    step_status_next = res_status_reg;
                    run_done_next    = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            prior_time_reg <= '0;
            prior_x_reg    <= '0;
            prior_y_reg    <= '0;
            have_prior_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            prior_time_reg <= prior_time_next;
            prior_x_reg    <= prior_x_next;
            prior_y_reg    <= prior_y_next;
            have_prior_reg <= have_prior_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        time1_reg       <= time1_next;
        time2_reg       <= time2_next;
        res_speed_reg   <= res_speed_next;
        res_status_reg  <= res_status_next;
        last_reg        <= last_next;
        speed_time_reg  <= speed_time_next;
        speed_value_reg <= speed_value_next;
        step_status_reg <= step_status_next;
        run_done_reg    <= run_done_next;
    end

    assign out_valid   = out_valid_reg;
    assign speed_time  = speed_time_reg;
    assign speed_value = speed_value_reg;
    assign step_status = step_status_reg;
    assign run_done    = run_done_reg;

    a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        eng_done |-> (state_reg == ST_CALC))
        else $error("engine result arrived outside calc");

    a_done_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
        eng_done |=> (state_reg == ST_EMIT_FIRST))
        else $error("engine result not forwarded");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (step_status_reg == STATUS_SINGLE)) |-> run_done_reg)
        else $error("one-sample status without run_done");

    a_back_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (step_status_reg == STATUS_TIME_BACK)) |-> (speed_value_reg == '0))
        else $error("nonzero speed on time fault");

endmodule

// ===== sim/speed_result_checker.sv =====
`timescale 1ns / 1ps

module speed_result_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic [31:0]                      sample_time,
    input  logic signed [31:0]               pos_x,
    input  logic signed [31:0]               pos_y,
    input  logic                             end_of_run,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic [31:0]                      speed_time,
    input  logic [psfp_pkg::SPEED_WIDTH-1:0] speed_value,
    input  logic [1:0]                       step_status,
    input  logic                             run_done,
    output int                               fail_count,
    output int                               pending_results
);
    import psfp_pkg::*;

    localparam logic [SPEED_WIDTH-1:0] SPEED_MAX = {SPEED_WIDTH{1'b1}};

    typedef struct packed {
        logic [31:0]            stamp;
        logic [SPEED_WIDTH-1:0] speed;
        logic [1:0]             status;
        logic                   done;
    } speed_result_t;

    speed_result_t speeds_due[$];

    // sample held from the previous beat of the current run
    logic               held_valid;
    logic [31:0]        held_stamp;
    logic signed [31:0] held_x;
    logic signed [31:0] held_y;
    int                 mismatches;

    // magnitude of a - b, fits in 32 bits for any pair of 32-bit signed values
    function automatic logic [32:0] span(input logic signed [31:0] a, input logic signed [31:0] b);
        logic signed [32:0] d;
        d = {a[31], a} - {b[31], b};
        return d[32] ? -d : d;
    endfunction

    // floor(isqrt((dx^2 + dy^2) << 32) / dt), saturated to the output width
    function automatic logic [SPEED_WIDTH-1:0] track_speed(input logic [32:0] dx_mag,
                                                           input logic [32:0] dy_mag,
                                                           input logic [31:0] dt);
        logic [127:0] ax;
        logic [127:0] ay;
        logic [127:0] rest;
        logic [127:0] root;
        logic [127:0] probe;
        logic [127:0] quot;
        ax = {95'd0, dx_mag};
        ay = {95'd0, dy_mag};
        rest = (ax * ax + ay * ay) << (2 * FRAC_BITS_DEF);
        root = '0;
        probe = 128'd1 << 126;
        while (probe > rest)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (rest >= root + probe)
            begin
                rest = rest - (root + probe);
                root = (root >> 1) + probe;
            end
            else
            begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        quot = root / {96'd0, dt};
        return (quot > {80'd0, SPEED_MAX}) ? SPEED_MAX : quot[SPEED_WIDTH-1:0];
    endfunction

    task automatic queue_result(input speed_result_t r);
        speeds_due = {speeds_due, r};
    endtask

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        speed_result_t due;
        logic [SPEED_WIDTH-1:0] spd;
        logic [1:0] st;
        if (!rst_n)
        begin
            held_valid <= 1'b0;
            held_stamp <= '0;
            held_x <= '0;
            held_y <= '0;
            speeds_due.delete();
            mismatches = 0;
            fail_count <= 0;
            pending_results <= 0;
        end
        else
        begin
            // results first: a result can never belong to a beat taken at the same edge
            if (out_valid && out_ready)
            begin
                if (speeds_due.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual %h %h %0d %b",
                             $time, speed_time, speed_value, step_status, run_done);
                    mismatches++;
                end
                else
                begin
                    due = speeds_due.pop_front();
                    check_field("speed_time", 64'(due.stamp), 64'(speed_time));
                    check_field("speed_value", 64'(due.speed), 64'(speed_value));
                    check_field("step_status", 64'(due.status), 64'(step_status));
                    check_field("run_done", 64'(due.done), 64'(run_done));
                end
            end

            if (in_valid && in_ready)
            begin
                if (!held_valid)
                begin
                    if (end_of_run)
                    begin
                        queue_result('{sample_time, '0, STATUS_SINGLE, 1'b1});
                    end
                    else
                    begin
                        held_valid <= 1'b1;
                        held_stamp <= sample_time;
                        held_x <= pos_x;
                        held_y <= pos_y;
                    end
                end
                else
                begin
                    if (sample_time <= held_stamp)
                    begin
                        spd = '0;
                        st = STATUS_TIME_BACK;
                    end
                    else
                    begin
                        spd = track_speed(span(pos_x, held_x), span(pos_y, held_y),
                                          sample_time - held_stamp);
                        st = STATUS_OK;
                    end
                    queue_result('{held_stamp, spd, st, 1'b0});
                    if (end_of_run)
                    begin
                        queue_result('{sample_time, spd, st, 1'b1});
                        held_valid <= 1'b0;
                        held_stamp <= '0;
                        held_x <= '0;
                        held_y <= '0;
                    end
                    else
                    begin
                        held_stamp <= sample_time;
                        held_x <= pos_x;
                        held_y <= pos_y;
                    end
                end
            end

            fail_count <= mismatches;
            pending_results <= speeds_due.size();
        end
    end

endmodule

// ===== sim/planar_speed_from_positions_unit_tb.sv =====
`timescale 1ns / 1ps

module planar_speed_from_positions_unit_tb;

    import psfp_pkg::*;

    localparam int SAMPLE_TOTAL   = 1800;
    localparam int CALM_TAIL      = 150;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 300;

    localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic [31:0]         TIME_MAX = 32'hFFFF_FFFF;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [31:0]            sample_time;
    logic signed [31:0]     pos_x;
    logic signed [31:0]     pos_y;
    logic                   end_of_run;
    logic                   out_valid;
    logic                   out_ready;
    logic [31:0]            speed_time;
    logic [SPEED_WIDTH-1:0] speed_value;
    logic [1:0]             step_status;
    logic                   run_done;

    int   fail_count;
    int   pending_results;
    int   samples_sent;
    int   quiet_cycles;
    int   hold_off;
    logic jitter;
    logic calm;

    planar_speed_from_positions_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .sample_time (sample_time),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .end_of_run  (end_of_run),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .speed_time  (speed_time),
        .speed_value (speed_value),
        .step_status (step_status),
        .run_done    (run_done)
    );

    speed_result_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .sample_time     (sample_time),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .end_of_run      (end_of_run),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .speed_time      (speed_time),
        .speed_value     (speed_value),
        .step_status     (step_status),
        .run_done        (run_done),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    always #1 clk = ~clk;

    // receiver stalls in bursts of random length while jitter is on and the tail is not calm
    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            out_ready <= 1'b0;
            hold_off <= hold_off - 1;
        end
        else if (jitter && !calm && $urandom_range(0, 5) == 0)
        begin
            out_ready <= 1'b0;
            hold_off <= $urandom_range(0, 2);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // one input beat, with an optional gap of random length in front of it while jitter is on
    task automatic send_sample(input logic [31:0] stamp, input logic signed [31:0] px,
                               input logic signed [31:0] py, input logic last);
        int gap;
        calm <= (samples_sent >= SAMPLE_TOTAL - CALM_TAIL);
        if (jitter && !calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample_time <= stamp;
        pos_x <= px;
        pos_y <= py;
        end_of_run <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        samples_sent++;
    endtask

    initial
    begin
        int run_len;
        logic [31:0] stamp;
        logic signed [31:0] px;
        logic signed [31:0] py;

        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        sample_time = '0;
        pos_x = '0;
        pos_y = '0;
        end_of_run = 1'b0;
        out_ready = 1'b0;
        hold_off = 0;
        quiet_cycles = 0;
        samples_sent = 0;
        jitter = 1'b0;
        calm = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one-sample runs, one of them at the extremes
        send_sample(32'd5, 32'sd100, -32'sd100, 1'b1);
        send_sample(TIME_MAX, POS_MAX, POS_MIN, 1'b1);
        // full-scale jump in one tick saturates, then equal and falling times
        send_sample(32'd0, POS_MIN, POS_MIN, 1'b0);
        send_sample(32'd1, POS_MAX, POS_MAX, 1'b0);
        send_sample(32'd1, POS_MAX, POS_MAX, 1'b0);
        send_sample(32'd0, 32'sd0, 32'sd0, 1'b0);
        send_sample(TIME_MAX, 32'sd3, 32'sd4, 1'b0);
        send_sample(32'h10, 32'sd0, 32'sd0, 1'b1);
        // 3-4-5 step, no motion, then a full-range move on the last beat
        send_sample(32'd1000, -32'sd7, 32'sd12, 1'b0);
        send_sample(32'd1003, -32'sd4, 32'sd16, 1'b0);
        send_sample(32'd1004, -32'sd4, 32'sd16, 1'b0);
        send_sample(32'd1006, POS_MAX, POS_MIN, 1'b1);
        // near the top of the time range
        send_sample(32'hFFFF_FFF0, 32'sd0, 32'sd0, 1'b0);
        send_sample(TIME_MAX, 32'sd1, 32'sd0, 1'b1);
        send_sample(32'd0, 32'sd0, 32'sd0, 1'b0);
        send_sample(32'd1, 32'sd1, 32'sd1, 1'b1);
        // equal zero times closing a run
        send_sample(32'd0, -32'sd1, -32'sd1, 1'b0);
        send_sample(32'd0, 32'sd1, 32'sd1, 1'b1);

        while (samples_sent < SAMPLE_TOTAL)
        begin
            run_len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 8);
            jitter <= ($urandom_range(0, 3) != 0);
            stamp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom;
            px = $urandom;
            py = $urandom;
            for (int k = 0; k < run_len; k++)
            begin
                send_sample(stamp, px, py, k == run_len - 1);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: stamp = stamp + $urandom_range(1, 16);
                    4, 5, 6:    stamp = stamp + $urandom_range(1, 65535);
                    7:          stamp = stamp + $urandom;
                    8:          stamp = stamp - $urandom_range(0, 3);
                    default:    stamp = $urandom;
                endcase
                case ($urandom_range(0, 7))
                    0, 1, 2, 3:
                    begin
                        px = px + $urandom_range(0, 2000) - 1000;
                        py = py + $urandom_range(0, 2000) - 1000;
                    end
                    4, 5:
                    begin
                        px = px + $urandom_range(0, 1 << 20) - (1 << 19);
                        py = py + $urandom_range(0, 1 << 20) - (1 << 19);
                    end
                    default:
                    begin
                        px = $urandom;
                        py = $urandom;
                    end
                endcase
            end
        end
        in_valid <= 1'b0;
        @(posedge clk);

        while (pending_results != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_results == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
